@@ hdl/bnmp_pkg.sv @@
// Shared constants and controller/datapath interface types for the max-period unit.
package bnmp_pkg;

  // Largest supported network and the widths that follow from it.
  localparam int MAX_NODES   = 6;
  localparam int NODE_W      = 6;                  // width of one input arc mask
  localparam int STATE_W     = MAX_NODES;          // one bit per node
  localparam int STATE_DEPTH = 1 << STATE_W;
  localparam int SCNT_W      = STATE_W + 1;        // holds STATE_DEPTH itself
  localparam int NCNT_W      = 3;                  // node count register width
  localparam int PERIOD_W    = 7;
  localparam int COUNT_W     = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_BITS     = MAX_NODES * NODE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * PERIOD_W + 2 * STATE_W + 1 + 3 * COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a graph and clear the per-graph marks
    logic begin_walk;  // start a walk at the current start state
    logic walk_step;   // mark the current state on the path and advance
    logic cyc_begin;   // walk hit its own path: begin measuring the cycle
    logic cyc_step;    // advance the cycle probe by one state
    logic cyc_end;     // cycle measured: keep it if it is the longest so far
    logic close;       // retire the path states as done
    logic next_start;  // move on to the next start state
    logic finish;      // update the running totals and present the result
  } bnmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_in;      // incoming graph is malformed
    logic start_done;  // start state already visited
    logic cur_done;    // walk reached a visited state
    logic cur_on;      // walk reached a state on its own path
    logic pos_hit;     // cycle probe is back at the hit state
    logic start_last;  // current start is the last state of the graph
    logic out_busy;    // result register still holds an untaken beat
  } bnmp_status_t;

endpackage

@@ hdl/bnmp_ctrl.sv @@
// Controller state machine that sequences the walk over all start states.
module bnmp_ctrl import bnmp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  bnmp_status_t status,
  output bnmp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_CYC   = 3'd3;
  localparam logic [2:0] ST_CLOSE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = status.bad_in ? ST_FIN : ST_START;
        end
      end
      ST_START: begin
        if (status.start_done) begin
          if (status.start_last) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.next_start = 1'b1;
          end
        end else begin
          cmd.begin_walk = 1'b1;
          state_nxt      = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.cur_done) begin
          state_nxt = ST_CLOSE;
        end else if (status.cur_on) begin
          cmd.cyc_begin = 1'b1;
          state_nxt     = ST_CYC;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_CYC: begin
        if (status.pos_hit) begin
          cmd.cyc_end = 1'b1;
          state_nxt   = ST_CLOSE;
        end else begin
          cmd.cyc_step = 1'b1;
        end
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        if (status.start_last) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.next_start = 1'b1;
          state_nxt      = ST_START;
        end
      end
      ST_FIN: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/bnmp_datapath.sv @@
// Datapath: graph capture, successor logic, walk marks, cycle probe and running totals.
module bnmp_datapath import bnmp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [NCNT_W-1:0]      cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  bnmp_cmd_t              cmd,
  output bnmp_status_t           status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  logic [NCNT_W-1:0]    node_count_r;
  logic [NCNT_W-1:0]    n_eff;
  logic [STATE_W-1:0]   state_lim;
  logic                 bad_in;

  logic [NODE_W-1:0]    masks_r [MAX_NODES];
  logic                 bad_r;
  logic [STATE_DEPTH-1:0] done_r;
  logic [STATE_DEPTH-1:0] on_r;
  logic [STATE_W-1:0]   start_r;
  logic [STATE_W-1:0]   cur_r;
  logic [STATE_W-1:0]   hit_r;
  logic [STATE_W-1:0]   pos_r;
  logic [PERIOD_W-1:0]  cnt_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [STATE_W-1:0]   cyc_start_r;
  logic [STATE_W-1:0]   cur_succ;
  logic [STATE_W-1:0]   pos_succ;

  logic [COUNT_W-1:0]   graphs_r, graphs_nxt;
  logic [PERIOD_W-1:0]  best_r, best_nxt;
  logic [COUNT_W-1:0]   attain_r, attain_nxt;
  logic [COUNT_W-1:0]   sbg_r, sbg_nxt;
  logic [STATE_W-1:0]   sbs_r, sbs_nxt;
  logic                 new_best;

  logic                 out_valid_r;
  logic [PERIOD_W-1:0]  o_period_r;
  logic [STATE_W-1:0]   o_start_r;
  logic                 o_new_best_r;
  logic                 o_bad_r;
  logic [COUNT_W-1:0]   o_graphs_r;
  logic [PERIOD_W-1:0]  o_best_r;
  logic [COUNT_W-1:0]   o_attain_r;
  logic [COUNT_W-1:0]   o_sbg_r;
  logic [STATE_W-1:0]   o_sbs_r;

  // Next network state: node v turns on when 2, 3 or 5 of its predecessors are on.
  function automatic logic [STATE_W-1:0] succ_of(
    input logic [STATE_W-1:0] s,
    input logic [NODE_W-1:0]  m [MAX_NODES]
  );
    logic [STATE_W-1:0] nxt;
    logic [3:0]         c;
    logic [NODE_W-1:0]  act;
    nxt = '0;
    for (int v = 0; v < MAX_NODES; v++) begin
      act = m[v] & NODE_W'(s);
      c   = '0;
      for (int u = 0; u < NODE_W; u++) begin
        c = c + 4'(act[u]);
      end
      nxt[v] = (c == 4'd2) || (c == 4'd3) || (c == 4'd5);
    end
    return nxt;
  endfunction

  // Effective node count and the highest state of the graph.
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (node_count_r > NCNT_W'(MAX_NODES)) begin
      n_eff = NCNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
    state_lim = STATE_W'((SCNT_W'(1) << n_eff) - SCNT_W'(1));
  end

  // Self-arcs and arcs from or into nodes beyond the node count.
  always_comb begin
    logic [NODE_W-1:0] m;
    bad_in = 1'b0;
    for (int v = 0; v < MAX_NODES; v++) begin
      m = in_tdata[v*NODE_W +: NODE_W];
      if (NCNT_W'(v) >= n_eff) begin
        if (m != '0) bad_in = 1'b1;
      end else begin
        if ((m >> n_eff) != '0) bad_in = 1'b1;
        if (m[v]) bad_in = 1'b1;
      end
    end
  end

  assign cur_succ = succ_of(cur_r, masks_r);
  assign pos_succ = succ_of(pos_r, masks_r);

  // Status back to the controller.
  always_comb begin
    status.bad_in     = bad_in;
    status.start_done = done_r[start_r];
    status.cur_done   = done_r[cur_r];
    status.cur_on     = on_r[cur_r];
    status.pos_hit    = (pos_r == hit_r);
    status.start_last = (start_r == state_lim);
    status.out_busy   = out_valid_r && !out_tready;
  end

  // Node count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCNT_W'(MAX_NODES);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // Visited and on-path marks, one flag per state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      on_r   <= '0;
    end else if (cmd.load) begin
      done_r <= '0;
      on_r   <= '0;
    end else if (cmd.close) begin
      done_r <= done_r | on_r;
      on_r   <= '0;
    end else if (cmd.walk_step) begin
      on_r[cur_r] <= 1'b1;
    end
  end

  // Walk and cycle probe registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int v = 0; v < MAX_NODES; v++) begin
        masks_r[v] <= in_tdata[v*NODE_W +: NODE_W];
      end
      bad_r       <= bad_in;
      start_r     <= '0;
      period_r    <= '0;
      cyc_start_r <= '0;
    end
    if (cmd.next_start) start_r <= start_r + STATE_W'(1);
    if (cmd.begin_walk) cur_r <= start_r;
    if (cmd.walk_step) cur_r <= cur_succ;
    if (cmd.cyc_begin) begin
      hit_r <= cur_r;
      pos_r <= cur_succ;
      cnt_r <= PERIOD_W'(1);
    end
    if (cmd.cyc_step) begin
      pos_r <= pos_succ;
      cnt_r <= cnt_r + PERIOD_W'(1);
    end
    if (cmd.cyc_end && (cnt_r > period_r)) begin
      period_r    <= cnt_r;
      cyc_start_r <= hit_r;
    end
  end

  // Running totals after this graph; malformed graphs change nothing.
  always_comb begin
    graphs_nxt = graphs_r;
    best_nxt   = best_r;
    attain_nxt = attain_r;
    sbg_nxt    = sbg_r;
    sbs_nxt    = sbs_r;
    new_best   = 1'b0;
    if (!bad_r) begin
      graphs_nxt = (graphs_r == '1) ? graphs_r : graphs_r + COUNT_W'(1);
      if (period_r > best_r) begin
        best_nxt   = period_r;
        attain_nxt = COUNT_W'(1);
        sbg_nxt    = graphs_nxt;
        sbs_nxt    = cyc_start_r;
        new_best   = 1'b1;
      end else if (period_r == best_r) begin
        attain_nxt = (attain_r == '1) ? attain_r : attain_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      graphs_r <= '0;
      best_r   <= '0;
      attain_r <= '0;
      sbg_r    <= '0;
      sbs_r    <= '0;
    end else if (cmd.finish) begin
      graphs_r <= graphs_nxt;
      best_r   <= best_nxt;
      attain_r <= attain_nxt;
      sbg_r    <= sbg_nxt;
      sbs_r    <= sbs_nxt;
    end
  end

  // Result register: holds one beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_period_r   <= period_r;
      o_start_r    <= cyc_start_r;
      o_new_best_r <= new_best;
      o_bad_r      <= bad_r;
      o_graphs_r   <= graphs_nxt;
      o_best_r     <= best_nxt;
      o_attain_r   <= attain_nxt;
      o_sbg_r      <= sbg_nxt;
      o_sbs_r      <= sbs_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_bad_r;
  assign out_tdata  = OUT_TDATA_W'({o_sbs_r, o_sbg_r, o_attain_r, o_best_r, o_graphs_r,
                                    o_new_best_r, o_start_r, o_period_r});

  // A state is never both retired and on the live path.
  a_marks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & on_r) == '0)
    else $error("state marked both done and on-path");

  // A malformed result carries no period.
  a_bad_no_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_bad_r) |-> (o_period_r == '0) && !o_new_best_r)
    else $error("malformed result with a period");

  // The running best never falls.
  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (best_r >= $past(best_r)))
    else $error("running best period decreased");

  // Once a best exists, at least one graph attains it.
  a_attain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (best_r != '0) |-> (attain_r != '0))
    else $error("best period with no attaining graph");

endmodule

@@ hdl/boolean_network_max_period_unit.sv @@
// Top level of the longest-cycle search over threshold Boolean networks.
//
// One input beat carries a digraph as six 6-bit incoming-arc masks; node v turns
// on when 2, 3 or 5 of its predecessors are on. The unit walks every state of the
// resulting functional graph from start state 0 upward and reports its longest
// cycle together with running totals over all well-formed graphs.
// The cfg port writes the node count (1 to 6, out-of-range values are clamped);
// write it only while no graph is in flight.
// Work per graph: a probe of each start state, the walk steps, a closing probe
// and a retire step per walk, and the steps around each cycle found; the walk
// and the cycle probe step through separate successor units, one state a
// cycle. The result is valid in the cycle in which the next graph can be taken.
// A malformed graph skips the walk. One graph is worked on at a time.
// The result sits in an output register: the next graph is taken in while it
// waits, and the unit only stalls before finishing that graph if the receiver
// still has not taken the previous beat.
// Reset clears the totals, the state marks and the result valid, and sets the
// node count to six.
module boolean_network_max_period_unit import bnmp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: node count.
  input  logic                   cfg_we,
  input  logic [NCNT_W-1:0]      cfg_wdata,
  // Input graphs.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // preds_of_node0 [5:0], preds_of_node1 [11:6], preds_of_node2 [17:12],
  // preds_of_node3 [23:18], preds_of_node4 [29:24], preds_of_node5 [35:30]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Results.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // graph_period [6:0], graph_cycle_start [12:7], is_new_best [13],
  // graphs_counted [45:14], best_period [52:46], attaining_graphs [84:53],
  // first_best_graph [116:85], first_best_start [122:117]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // malformed [0]
  output logic                   out_tuser
);

  bnmp_cmd_t    cmd;
  bnmp_status_t status;

  bnmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bnmp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ bench/tb_boolean_network_max_period_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the longest-cycle search unit over threshold Boolean networks.
module tb_boolean_network_max_period_unit;
  import bnmp_pkg::*;

  // One result beat as it is expected: malformed flag above the out_tdata fields.
  typedef struct packed {
    logic                malformed;
    logic [STATE_W-1:0]  first_start;
    logic [COUNT_W-1:0]  first_graph;
    logic [COUNT_W-1:0]  attaining;
    logic [PERIOD_W-1:0] best;
    logic [COUNT_W-1:0]  counted;
    logic                new_best;
    logic [STATE_W-1:0]  cycle_start;
    logic [PERIOD_W-1:0] period;
  } network_report_t;

  // One directed graph: node count to run it with, arc masks (node 5 in the top bits)
  // and, where it is plain to see, the per-graph answer.
  typedef struct packed {
    logic [NCNT_W-1:0]   ncount;
    logic [IN_BITS-1:0]  masks;
    logic                typed;
    logic [PERIOD_W-1:0] period;
    logic [STATE_W-1:0]  cycle_start;
    logic                malformed;
  } graph_row_t;

  // Ways of breaking a graph in the random part.
  typedef enum int {SELF_ARC, STRAY_BIT, EXTRA_NODE, NOISE} fault_kind_t;

  localparam int RANDOM_PHASES    = 10;
  localparam int GRAPHS_PER_PHASE = 150;
  localparam int LONG_STALL       = 600;
  localparam int BROKEN_PCT       = 15;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [NCNT_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Shadow of the node count register and of the running totals.
  logic [NCNT_W-1:0]      node_count_reg = 3'd6;
  logic [COUNT_W-1:0]     total_graphs = '0;
  logic [COUNT_W-1:0]     total_attaining = '0;
  logic [COUNT_W-1:0]     best_graph_no = '0;
  logic [PERIOD_W-1:0]    best_period = '0;
  logic [STATE_W-1:0]     best_start = '0;

  network_report_t pending_reports[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_requests = 0;
  int failures = 0;
  int beats_checked = 0;
  int graphs_sent = 0;
  int bad_sent = 0;

  // Node count settings of the random phases, clamped values among them.
  logic [NCNT_W-1:0] phase_counts [RANDOM_PHASES] =
    '{3'd6, 3'd2, 3'd4, 3'd1, 3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd4};

  // Directed graphs; masks are written node 5 first, node 0 last.
  graph_row_t directed_rows [22] = '{
    '{3'd6, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd1, 6'd0, 1'b0},
    '{3'd6, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o01}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd6, {6'o40, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd6, {6'o00, 6'o00, 6'o77, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd6, {6'o37, 6'o57, 6'o67, 6'o73, 6'o75, 6'o76}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd6, {6'o20, 6'o10, 6'o04, 6'o02, 6'o01, 6'o40}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd6, {6'o03, 6'o41, 6'o60, 6'o30, 6'o14, 6'o06}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd6, {6'o07, 6'o43, 6'o61, 6'o70, 6'o34, 6'o16}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd6, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o76}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd1, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd1, 6'd0, 1'b0},
    '{3'd1, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o01}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd1, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o02}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd1, {6'o40, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd0, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd1, 6'd0, 1'b0},
    '{3'd0, {6'o00, 6'o00, 6'o00, 6'o00, 6'o01, 6'o00}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd3, {6'o00, 6'o00, 6'o00, 6'o03, 6'o05, 6'o06}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd3, {6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o10}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd3, {6'o00, 6'o00, 6'o01, 6'o00, 6'o00, 6'o00}, 1'b1, 7'd0, 6'd0, 1'b1},
    '{3'd7, {6'o37, 6'o57, 6'o67, 6'o73, 6'o75, 6'o76}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd7, {6'o37, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd7, {6'o00, 6'o40, 6'o00, 6'o00, 6'o00, 6'o00}, 1'b0, 7'd0, 6'd0, 1'b0},
    '{3'd2, {6'o00, 6'o00, 6'o00, 6'o00, 6'o01, 6'o02}, 1'b0, 7'd0, 6'd0, 1'b0}
  };

  boolean_network_max_period_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Effective node count after clamping.
  function automatic int unsigned clamp_nodes(input logic [NCNT_W-1:0] ncount);
    if (ncount == 0) return 1;
    if (ncount > MAX_NODES) return MAX_NODES;
    return 32'(ncount);
  endfunction

  // Validate the masks, build the state successors and walk them from state 0
  // upward; the first cycle of greatest length wins.
  function automatic void search_longest_cycle(input logic [IN_BITS-1:0] masks,
      input logic [NCNT_W-1:0] ncount, output logic [PERIOD_W-1:0] period,
      output logic [STATE_W-1:0] cyc_start, output logic bad);
    int unsigned        n;
    int unsigned        states;
    int unsigned        len;
    int unsigned        cnt;
    int unsigned        s;
    logic [NODE_W-1:0]  m;
    logic [STATE_W-1:0] succ [STATE_DEPTH];
    bit                 visited [STATE_DEPTH];
    bit                 on_path [STATE_DEPTH];
    int unsigned        step_no [STATE_DEPTH];
    int unsigned        path [STATE_DEPTH];
    period = '0;
    cyc_start = '0;
    bad = 1'b0;
    n = clamp_nodes(ncount);
    for (int v = 0; v < MAX_NODES; v++) begin
      m = masks[v*NODE_W +: NODE_W];
      if (v >= n) begin
        if (m != 0) bad = 1'b1;
      end else if ((m >> n) != 0 || m[v]) begin
        bad = 1'b1;
      end
    end
    if (bad) return;

    states = 1 << n;
    for (s = 0; s < states; s++) begin
      succ[s] = '0;
      for (int v = 0; v < n; v++) begin
        cnt = $countones(STATE_W'(s) & masks[v*NODE_W +: NODE_W]);
        if (cnt == 2 || cnt == 3 || cnt == 5) succ[s][v] = 1'b1;
      end
      visited[s] = 1'b0;
      on_path[s] = 1'b0;
    end

    for (int unsigned start = 0; start < states; start++) begin
      if (!visited[start]) begin
        len = 0;
        s = start;
        while (!visited[s] && !on_path[s]) begin
          on_path[s] = 1'b1;
          step_no[s] = len;
          path[len] = s;
          len++;
          s = 32'(succ[s]);
        end
        if (!visited[s] && on_path[s] && (len - step_no[s]) > period) begin
          period = PERIOD_W'(len - step_no[s]);
          cyc_start = STATE_W'(s);
        end
        for (int unsigned i = 0; i < len; i++) begin
          visited[path[i]] = 1'b1;
          on_path[path[i]] = 1'b0;
        end
      end
    end
  endfunction

  // Expected result for one accepted graph; advances the running totals.
  function automatic network_report_t predict_network_report(input logic [IN_BITS-1:0] masks);
    network_report_t     r;
    logic [PERIOD_W-1:0] period;
    logic [STATE_W-1:0]  cstart;
    logic                bad;
    search_longest_cycle(masks, node_count_reg, period, cstart, bad);
    r = '0;
    r.malformed = bad;
    r.period = period;
    r.cycle_start = cstart;
    if (!bad) begin
      if (total_graphs != '1) total_graphs++;
      if (period > best_period) begin
        best_period = period;
        total_attaining = 1;
        best_graph_no = total_graphs;
        best_start = cstart;
        r.new_best = 1'b1;
      end else if (period == best_period && total_attaining != '1) begin
        total_attaining++;
      end
    end
    r.counted = total_graphs;
    r.best = best_period;
    r.attaining = total_attaining;
    r.first_graph = best_graph_no;
    r.first_start = best_start;
    return r;
  endfunction

  // Random graph for the given node count, well formed unless asked to break it.
  function automatic logic [IN_BITS-1:0] random_graph(input logic [NCNT_W-1:0] ncount,
      input bit broken);
    int unsigned        n;
    int unsigned        v;
    fault_kind_t        fault;
    logic [IN_BITS-1:0] masks;
    logic [NODE_W-1:0]  legal;
    n = clamp_nodes(ncount);
    masks = '0;
    legal = NODE_W'((1 << n) - 1);
    for (v = 0; v < n; v++) begin
      masks[v*NODE_W +: NODE_W] = NODE_W'($urandom) & legal & ~(NODE_W'(1) << v);
      // Thin some nodes out so that sparse networks turn up too.
      if ($urandom_range(3) == 0) masks[v*NODE_W +: NODE_W] &= NODE_W'($urandom);
    end
    if (broken) begin
      if (n == MAX_NODES) fault = ($urandom_range(1) == 0) ? SELF_ARC : NOISE;
      else fault = fault_kind_t'($urandom_range(3));
      case (fault)
        SELF_ARC: begin
          v = $urandom_range(n - 1);
          masks[v*NODE_W + v] = 1'b1;
        end
        STRAY_BIT: begin
          v = $urandom_range(n - 1);
          masks[v*NODE_W + $urandom_range(NODE_W - 1, n)] = 1'b1;
        end
        EXTRA_NODE: begin
          v = $urandom_range(MAX_NODES - 1, n);
          masks[v*NODE_W +: NODE_W] = NODE_W'($urandom_range(63, 1));
        end
        default: begin
          masks = IN_BITS'({$urandom, $urandom});
        end
      endcase
    end
    return masks;
  endfunction

  // Offer one graph, possibly after a gap, and queue its expectation once taken.
  task automatic send_graph(input logic [IN_BITS-1:0] masks, input logic typed,
      input logic [PERIOD_W-1:0] period, input logic [STATE_W-1:0] cstart,
      input logic bad);
    network_report_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(masks);
    do @(posedge clk); while (!in_tready);
    r = predict_network_report(masks);
    if (typed) begin
      r.period = period;
      r.cycle_start = cstart;
      r.malformed = bad;
    end
    pending_reports.insert(pending_reports.size(), r);
    graphs_sent++;
    if (r.malformed) bad_sent++;
  endtask

  // Let every outstanding result drain, then write the node count.
  task automatic set_node_count(input logic [NCNT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_reg = value;
  endtask

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
      input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("Mismatch in %s on result %0d: expected %0d, got %0d",
                 field, beats_checked, want, got);
    end
  endtask

  // Graph side: directed table, then random phases, then the final wait.
  initial begin : graph_side
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 19;
    rx_idle_pct = 74;
    for (int i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].ncount != node_count_reg) set_node_count(directed_rows[i].ncount);
      send_graph(directed_rows[i].masks, directed_rows[i].typed, directed_rows[i].period,
                 directed_rows[i].cycle_start, directed_rows[i].malformed);
    end

    k = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_node_count(phase_counts[p]);
      // Small graphs finish fast, so a long output stall here backs up the input.
      if (p == 1) stall_requests++;
      for (int j = 0; j < GRAPHS_PER_PHASE; j++) begin
        if (k < RANDOM_PHASES * GRAPHS_PER_PHASE / 3) begin
          tx_idle_pct = 19;
          rx_idle_pct = 74;
        end else if (k < 2 * RANDOM_PHASES * GRAPHS_PER_PHASE / 3) begin
          tx_idle_pct = 74;
          rx_idle_pct = 19;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        send_graph(random_graph(phase_counts[p], $urandom_range(99) < BROKEN_PCT),
                   1'b0, '0, '0, 1'b0);
        k++;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Ran %0d graphs (%0d malformed) over node counts 0 to 7 with idle mixes",
             graphs_sent, bad_sent);
    $display("and a long output stall; %0d results checked, best period %0d.",
             beats_checked, best_period);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("tb_boolean_network_max_period_unit: done, clean");
    end else begin
      $display("tb_boolean_network_max_period_unit: done, errors");
    end
    $finish;
  end

  // Result side: random back-pressure, the long stall, and checking of each beat.
  initial begin : result_side
    int              stall_left;
    int              stall_served;
    network_report_t got;
    network_report_t want;
    stall_left = 0;
    stall_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[OUT_BITS-1:0]};
        if (pending_reports.size() == 0) begin
          failures++;
          if (failures <= 10) $display("Result beat arrived with nothing expected");
        end else begin
          want = pending_reports.pop_front();
          check_field("graph_period", COUNT_W'(want.period), COUNT_W'(got.period));
          check_field("graph_cycle_start", COUNT_W'(want.cycle_start),
                      COUNT_W'(got.cycle_start));
          check_field("is_new_best", COUNT_W'(want.new_best), COUNT_W'(got.new_best));
          check_field("malformed", COUNT_W'(want.malformed), COUNT_W'(got.malformed));
          check_field("graphs_counted", want.counted, got.counted);
          check_field("best_period", COUNT_W'(want.best), COUNT_W'(got.best));
          check_field("attaining_graphs", want.attaining, got.attaining);
          check_field("first_best_graph", want.first_graph, got.first_graph);
          check_field("first_best_start", COUNT_W'(want.first_start),
                      COUNT_W'(got.first_start));
          beats_checked++;
        end
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("tb_boolean_network_max_period_unit: done, errors");
    $finish;
  end

endmodule
